@@ hw/rtl/pmic_pkg.sv @@
// ----------------------------------------------------------------------------
// pmic_pkg: shared types and constants of the poll-mode interrupt controller
// Transaction layouts, bus command codes, init step codes and 8259A
// control word fields used by the controller modules.
// ----------------------------------------------------------------------------
package pmic_pkg;

   localparam int unsigned AddrWidth  = 24;
   localparam int unsigned LineCount  = 8;
   localparam int unsigned IndexWidth = 1;

   typedef enum logic [1:0] {
      CMD_READ  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_TICK  = 2'd2
   } command_type;

   localparam logic [IndexWidth-1:0] CSR_BASE_ADDRESS = 1'd0;
   localparam logic [IndexWidth-1:0] CSR_ADDRESS_MASK = 1'd1;

   localparam logic [2:0] STEP_DONE = 3'd0;
   localparam logic [2:0] STEP_ICW4 = 3'd1;
   localparam logic [2:0] STEP_ICW3 = 3'd2;
   localparam logic [2:0] STEP_ICW2 = 3'd3;
   localparam logic [2:0] STEP_ICW1 = 3'd4;

   localparam logic [1:0] WR_OCW2 = 2'b00;
   localparam logic [1:0] WR_OCW3 = 2'b01;
   localparam logic [1:0] WR_ICW1 = 2'b10;

   localparam logic [2:0] OCW2_NS_EOI = 3'b001;
   localparam logic [2:0] OCW2_SP_EOI = 3'b011;

   localparam logic [7:0] READ_MODE_INIT = 8'h4A;
   localparam logic [7:0] POLL_FLAG      = 8'h80;
   localparam logic [7:0] LATCH_ARMED    = 8'hFF;
   localparam logic [2:0] NO_LEVEL       = 3'd7;

   localparam logic [AddrWidth-1:0] BASE_ADDRESS_RESET = 24'h000020;
   localparam logic [AddrWidth-1:0] ADDRESS_MASK_RESET = 24'hFFFFFE;

   typedef struct packed {
      logic [1:0]           command;
      logic                 io_space;
      logic [AddrWidth-1:0] bus_address;
      logic [7:0]           write_data;
      logic [LineCount-1:0] int_lines;
   } req_item_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       selected;
      logic       int_request;
   } rsp_item_type;

   typedef struct packed {
      logic [AddrWidth-1:0] base_address;
      logic [AddrWidth-1:0] address_mask;
   } addr_cfg_type;

   typedef struct packed {
      logic       found;
      logic [2:0] level;
   } priority_type;

   function automatic priority_type lowest_set(input logic [LineCount-1:0] value);
      priority_type res;
      res.found = 1'b0;
      res.level = NO_LEVEL;
      for (int i = LineCount - 1; i >= 0; i--) begin
         if (value[i]) begin
            res.found = 1'b1;
            res.level = 3'(i);
         end
      end
      return res;
   endfunction

endpackage

@@ hw/rtl/pmic_csr.sv @@
// ----------------------------------------------------------------------------
// pmic_csr: address decode configuration registers
// Holds the base address and address mask written over the CSR channel.
// ----------------------------------------------------------------------------
module pmic_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pmic_pkg::IndexWidth-1:0]   csr_index,
   input  logic [pmic_pkg::AddrWidth-1:0]    csr_data,
   output pmic_pkg::addr_cfg_type            addr_cfg
);
   import pmic_pkg::*;

   addr_cfg_type cfg_ff;
   addr_cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign addr_cfg  = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_BASE_ADDRESS: cfg_in.base_address = csr_data;
            CSR_ADDRESS_MASK: cfg_in.address_mask = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{base_address: BASE_ADDRESS_RESET, address_mask: ADDRESS_MASK_RESET};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ hw/rtl/pmic_core.sv @@
// ----------------------------------------------------------------------------
// pmic_core: controller state and single-pass transaction logic
// Decodes one registered transaction against the controller state and
// produces its result together with the next state.
// ----------------------------------------------------------------------------
module pmic_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   item_valid,
   input  pmic_pkg::req_item_type item,
   input  pmic_pkg::addr_cfg_type addr_cfg,
   output pmic_pkg::rsp_item_type result
);
   import pmic_pkg::*;

   typedef struct packed {
      logic [2:0]           init_step;
      logic [7:0]           init_word_one;
      logic [7:0]           init_word_two;
      logic [7:0]           init_word_three;
      logic [7:0]           init_word_four;
      logic [7:0]           mask_reg;
      logic [7:0]           read_mode_reg;
      logic [LineCount-1:0] in_service;
      logic [LineCount-1:0] request_reg;
      logic [LineCount-1:0] edge_latch;
      logic [LineCount-1:0] previous_lines;
      logic                 request_frozen;
      logic                 pending_flag;
   } pic_state_type;

   localparam pic_state_type STATE_RESET = '{
      init_step:       STEP_ICW1,
      init_word_one:   8'h00,
      init_word_two:   8'h00,
      init_word_three: 8'h00,
      init_word_four:  8'h00,
      mask_reg:        8'h00,
      read_mode_reg:   8'h00,
      in_service:      '0,
      request_reg:     '0,
      edge_latch:      LATCH_ARMED,
      previous_lines:  '0,
      request_frozen:  1'b0,
      pending_flag:    1'b0
   };

   pic_state_type state_ff;
   pic_state_type state_in;

   logic                 addr_hit;
   logic [LineCount-1:0] live;
   logic [LineCount-1:0] fresh_request;
   logic [LineCount-1:0] grant_bit;
   priority_type         grant;

   assign addr_hit = item.io_space &&
                     ((item.bus_address & addr_cfg.address_mask) == addr_cfg.base_address);
   assign live      = state_ff.request_reg & ~state_ff.mask_reg;
   assign grant     = lowest_set(live);
   assign grant_bit = grant.found ? (LineCount'(1) << grant.level) : '0;
   assign fresh_request = state_ff.request_frozen ? state_ff.request_reg
                                                  : (state_ff.edge_latch & item.int_lines);

   always_comb begin
      state_in        = state_ff;
      result          = '0;
      if (item_valid) begin
         unique case (item.command)
            CMD_TICK: begin
               state_in.request_reg = fresh_request;
               if ((fresh_request & ~state_ff.mask_reg) != '0) begin
                  state_in.pending_flag = 1'b1;
               end
               state_in.edge_latch     = state_ff.edge_latch |
                                         (~item.int_lines & state_ff.previous_lines);
               state_in.previous_lines = item.int_lines;
            end
            CMD_WRITE: begin
               if (addr_hit) begin
                  result.selected = 1'b1;
                  if (state_ff.init_step != STEP_DONE) begin
                     unique case (state_ff.init_step)
                        STEP_ICW1: begin
                           state_in.init_word_one = item.write_data;
                           state_in.read_mode_reg = READ_MODE_INIT;
                           state_in.init_step     = STEP_ICW2;
                        end
                        STEP_ICW2: begin
                           state_in.init_word_two = item.write_data;
                           if (!state_ff.init_word_one[1]) begin
                              state_in.init_step = STEP_ICW3;
                           end else begin
                              state_in.init_step = state_ff.init_word_one[0] ? STEP_ICW4
                                                                              : STEP_DONE;
                           end
                        end
                        STEP_ICW3: begin
                           state_in.init_word_three = item.write_data;
                           state_in.init_step = state_ff.init_word_one[0] ? STEP_ICW4
                                                                           : STEP_DONE;
                        end
                        default: begin
                           state_in.init_word_four = item.write_data;
                           state_in.init_step      = STEP_DONE;
                        end
                     endcase
                  end else if (item.bus_address[0]) begin
                     state_in.mask_reg = item.write_data;
                  end else begin
                     case (item.write_data[4:3])
                        WR_OCW2: begin
                           if (item.write_data[7:5] == OCW2_NS_EOI) begin
                              state_in.request_frozen = 1'b0;
                              state_in.request_reg    = '0;
                              state_in.pending_flag   = 1'b0;
                              state_in.in_service     = state_ff.in_service &
                                                        (state_ff.in_service - 1'b1);
                           end else if (item.write_data[7:5] == OCW2_SP_EOI) begin
                              state_in.request_frozen = 1'b0;
                              state_in.request_reg    = '0;
                              state_in.pending_flag   = 1'b0;
                              state_in.in_service     = state_ff.in_service &
                                 ~(LineCount'(1) << item.write_data[2:0]);
                           end
                        end
                        WR_OCW3: state_in.read_mode_reg = item.write_data;
                        WR_ICW1: state_in.init_word_one = item.write_data;
                        default: ;
                     endcase
                  end
               end
            end
            CMD_READ: begin
               if (addr_hit) begin
                  result.selected = 1'b1;
                  if (item.bus_address[0]) begin
                     result.read_data = state_ff.mask_reg;
                  end else if (state_ff.read_mode_reg[2]) begin
                     if (state_ff.pending_flag) begin
                        state_in.request_frozen = 1'b1;
                        state_in.in_service     = state_ff.in_service | grant_bit;
                        state_in.edge_latch     = state_ff.edge_latch & ~grant_bit;
                        state_in.pending_flag   = 1'b0;
                        result.read_data        = POLL_FLAG | {5'b0, grant.level};
                     end
                     state_in.read_mode_reg = state_ff.read_mode_reg & ~8'h04;
                  end else if (state_ff.read_mode_reg[1:0] == 2'b10) begin
                     result.read_data = state_ff.request_reg;
                  end else if (state_ff.read_mode_reg[1:0] == 2'b11) begin
                     result.read_data = state_ff.in_service;
                  end
               end
            end
            default: ;
         endcase
      end
      result.int_request = state_in.pending_flag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ hw/rtl/poll_mode_interrupt_controller_unit.sv @@
// ----------------------------------------------------------------------------
// poll_mode_interrupt_controller_unit: eight-input poll-mode interrupt controller
//
//   Channel   Handshake                 Payload
//   req       start / busy              command, io_space, bus_address,
//                                       write_data, int_lines
//   rsp       rsp_valid (strobe)        read_data, selected, int_request
//   csr       csr_valid / csr_ready     csr_index, csr_data
//
// One transaction is accepted per cycle; busy stays low.
// Each accepted transaction is held in the input register, then decoded with the
// state update, and its result is captured in the result register, which drives
// the result ports.
// Reset is synchronous and restores the post-reset controller state.
// The receiver cannot stall; every result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module poll_mode_interrupt_controller_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [1:0]                      req_command,
   input  logic                            req_io_space,
   input  logic [pmic_pkg::AddrWidth-1:0]  req_bus_address,
   input  logic [7:0]                      req_write_data,
   input  logic [pmic_pkg::LineCount-1:0]  req_int_lines,
   output logic                            rsp_valid,
   output logic [7:0]                      rsp_read_data,
   output logic                            rsp_selected,
   output logic                            rsp_int_request,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [pmic_pkg::IndexWidth-1:0] csr_index,
   input  logic [pmic_pkg::AddrWidth-1:0]  csr_data
);
   import pmic_pkg::*;

   logic         item_valid_ff;
   req_item_type item_ff;
   req_item_type item_in;
   logic         rsp_valid_ff;
   rsp_item_type rsp_ff;
   rsp_item_type core_result;
   addr_cfg_type addr_cfg;

   assign busy = 1'b0;

   assign item_in.command     = req_command;
   assign item_in.io_space    = req_io_space;
   assign item_in.bus_address = req_bus_address;
   assign item_in.write_data  = req_write_data;
   assign item_in.int_lines   = req_int_lines;

   pmic_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .addr_cfg  (addr_cfg)
   );

   pmic_core u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid_ff),
      .item       (item_ff),
      .addr_cfg   (addr_cfg),
      .result     (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         rsp_ff        <= '0;
      end else begin
         item_valid_ff <= start && !busy;
         rsp_valid_ff  <= item_valid_ff;
         if (item_valid_ff) begin
            rsp_ff <= core_result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         item_ff <= item_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_data   = rsp_ff.read_data;
   assign rsp_selected    = rsp_ff.selected;
   assign rsp_int_request = rsp_ff.int_request;

`ifndef SYNTHESIS
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_valid)
      else $error("accepted transaction produced no result");

   a_data_needs_select: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_read_data != 8'h00) |-> rsp_selected)
      else $error("read data returned for an unselected transaction");

   a_irq_holds_idle: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> $stable(rsp_int_request))
      else $error("interrupt request changed without a result");
`endif

endmodule
